// File: hdl/brush_line_rasterizer_defines.svh
// assertion helpers shared by the rasterizer rtl
`ifndef BRUSH_LINE_RASTERIZER_DEFINES_SVH
`define BRUSH_LINE_RASTERIZER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define BRL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define BRL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/brl_pkg.sv
package brl_pkg;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;

  localparam int OP_W      = 2;
  localparam int COORD_W   = 8;
  localparam int COLOUR_W  = 16;
  localparam int BRUSH_W   = 4;
  localparam int HALF_W    = BRUSH_W - 1;
  localparam int PAGE_W    = 9;
  localparam int CFG_IDX_W = 1;
  // signed texel position: coordinate plus brush offset, with room below zero
  localparam int POS_W     = PAGE_W + 2;
  localparam int ERR_W     = COORD_W + 3;

  localparam logic [PAGE_W-1:0] PAGE_WIDTH_RST  = 9'd256;
  localparam logic [PAGE_W-1:0] PAGE_HEIGHT_RST = 9'd192;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_DOT   = 2'd1,
    OP_LINE  = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAGE_WIDTH  = 1'b0,
    REG_PAGE_HEIGHT = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STAMP,
    ST_READ,
    ST_FINISH
  } state_t;

endpackage

// File: hdl/brl_cfg_if.sv
interface brl_cfg_if;
  import brl_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [PAGE_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/brl_in_if.sv
interface brl_in_if;
  import brl_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [COORD_W-1:0]  start_x;
  logic [COORD_W-1:0]  start_y;
  logic [COORD_W-1:0]  end_x;
  logic [COORD_W-1:0]  end_y;
  logic [COLOUR_W-1:0] colour;
  logic [BRUSH_W-1:0]  brush_width;

  modport source (output valid, output op, output start_x, output start_y, output end_x,
                  output end_y, output colour, output brush_width, input ready);
  modport sink   (input valid, input op, input start_x, input start_y, input end_x,
                  input end_y, input colour, input brush_width, output ready);
endinterface

// File: hdl/brl_out_if.sv
interface brl_out_if;
  import brl_pkg::*;

  logic                valid;
  logic                ready;
  logic [COLOUR_W-1:0] pixel_value;
  logic                in_page;

  modport source (output valid, output pixel_value, output in_page, input ready);
  modport sink   (input valid, input pixel_value, input in_page, output ready);
endinterface

// File: hdl/brush_line_rasterizer.sv
// channel | dir | beat carries
// --------+-----+------------------------------------------------------------
// cfg     | in  | index (0 page_width, 1 page_height), data
// cmd     | in  | op, start_x, start_y, end_x, end_y, colour, brush_width
// rsp     | out | pixel_value, in_page
//
// one item at a time; the page store port writes one texel per cycle.
// write pixel stamps one texel; dot stamps a (2h+1) x (2h+1) square, h = brush_width/2.
// line stamps that square at each of n+1 points, n = max(|dx|, |dy|); read fetches one texel.
// rst clears control and restores page size 256 x 192; store is not cleared.
// rsp has its own register: cmd is taken while a result waits on rsp.ready.
// a finished item stalls only when the previous result is still unread.
`include "brush_line_rasterizer_defines.svh"

module brush_line_rasterizer #(
  parameter int MAX_WIDTH  = brl_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = brl_pkg::MAX_HEIGHT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  brl_cfg_if.sink   cfg,
  brl_in_if.sink    cmd,
  brl_out_if.source rsp
);
  import brl_pkg::*;

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [COLOUR_W-1:0] page_store [DEPTH];

  state_t state, state_next;

  logic [PAGE_W-1:0] page_width, page_height;
  logic [PAGE_W-1:0] clip_w, clip_h;

  // item registers
  logic [COORD_W-1:0]     end_x, end_y, cx, cy, ax, ay;
  logic [COLOUR_W-1:0]    colour;
  logic [HALF_W-1:0]      half;
  logic signed [BRUSH_W-1:0] ox, oy;
  logic signed [ERR_W-1:0]   err;
  logic                   stx, sty;
  logic                   rd_hit;

  // write port stage
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [COLOUR_W-1:0] wr_data;
  logic [COLOUR_W-1:0] rd_data;

  logic                rsp_valid;
  logic [COLOUR_W-1:0] rsp_pixel;
  logic                rsp_in_page;

  logic accept, rd_en, load_rsp;

  // accept-time decode
  logic [COORD_W-1:0]    sx_in, sy_in;
  logic [HALF_W-1:0]     half_in;
  logic [COORD_W:0]      dx, dy, ndx, ndy;
  logic [COORD_W-1:0]    ax_in, ay_in;
  logic signed [BRUSH_W-1:0] half_in_s, half_s;

  // texel path
  logic signed [POS_W-1:0] tx, ty;
  logic                    tex_ok;
  logic [ADDR_W-1:0]       tex_addr;
  logic                    ox_last, oy_last, at_end;
  logic                    offs_ok;

  logic signed [ERR_W:0]   twice, ax_e, neg_ay;
  logic                    step_x, step_y;
  logic signed [ERR_W-1:0] err_next;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_width  <= PAGE_WIDTH_RST;
      page_height <= PAGE_HEIGHT_RST;
    end else if (cfg.valid) begin
      unique case (reg_idx_t'(cfg.index))
        REG_PAGE_WIDTH:  page_width  <= cfg.data;
        REG_PAGE_HEIGHT: page_height <= cfg.data;
        default: ;
      endcase
    end
  end

  assign clip_w = (int'(page_width) > MAX_WIDTH) ? PAGE_W'(MAX_WIDTH) : page_width;
  assign clip_h = (int'(page_height) > MAX_HEIGHT) ? PAGE_W'(MAX_HEIGHT) : page_height;

  // write pixel and dot are degenerate lines
  assign sx_in   = (op_t'(cmd.op) == OP_LINE) ? cmd.start_x : cmd.end_x;
  assign sy_in   = (op_t'(cmd.op) == OP_LINE) ? cmd.start_y : cmd.end_y;
  assign half_in = (op_t'(cmd.op) == OP_DOT || op_t'(cmd.op) == OP_LINE) ?
                   cmd.brush_width[BRUSH_W-1:1] : '0;
  assign dx  = {1'b0, cmd.end_x} - {1'b0, sx_in};
  assign dy  = {1'b0, cmd.end_y} - {1'b0, sy_in};
  assign ndx = -dx;
  assign ndy = -dy;
  assign ax_in = dx[COORD_W] ? ndx[COORD_W-1:0] : dx[COORD_W-1:0];
  assign ay_in = dy[COORD_W] ? ndy[COORD_W-1:0] : dy[COORD_W-1:0];
  assign half_in_s = $signed({1'b0, half_in});
  assign half_s    = $signed({1'b0, half});

  assign tx = $signed({{(POS_W-COORD_W){1'b0}}, cx}) +
              $signed({{(POS_W-BRUSH_W){ox[BRUSH_W-1]}}, ox});
  assign ty = $signed({{(POS_W-COORD_W){1'b0}}, cy}) +
              $signed({{(POS_W-BRUSH_W){oy[BRUSH_W-1]}}, oy});
  assign tex_ok = !tx[POS_W-1] && !ty[POS_W-1] &&
                  (tx[POS_W-2:0] < {1'b0, clip_w}) && (ty[POS_W-2:0] < {1'b0, clip_h});
  // fixed row stride; only used when on the page, so it stays inside the store
  assign tex_addr = ADDR_W'(int'(ty[POS_W-2:0]) * MAX_WIDTH + int'(tx[POS_W-2:0]));

  assign ox_last = (ox == half_s);
  assign oy_last = (oy == half_s);
  assign at_end  = (cx == end_x) && (cy == end_y);
  assign offs_ok = (ox <= half_s) && (ox >= -half_s) && (oy <= half_s) && (oy >= -half_s);

  // bresenham error step
  assign twice    = {err, 1'b0};
  assign ax_e     = $signed({{(ERR_W+1-COORD_W){1'b0}}, ax});
  assign neg_ay   = -$signed({{(ERR_W+1-COORD_W){1'b0}}, ay});
  assign step_x   = twice > neg_ay;
  assign step_y   = twice < ax_e;
  assign err_next = err - (step_x ? $signed({{(ERR_W-COORD_W){1'b0}}, ay}) : '0)
                        + (step_y ? $signed({{(ERR_W-COORD_W){1'b0}}, ax}) : '0);

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd.ready  = 1'b0;
    rd_en      = 1'b0;
    load_rsp   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cmd.ready = 1'b1;
        if (cmd.valid) state_next = (op_t'(cmd.op) == OP_READ) ? ST_READ : ST_STAMP;
      end
      ST_STAMP: begin
        if (ox_last && oy_last && at_end) state_next = ST_FINISH;
      end
      ST_READ: begin
        rd_en      = tex_ok;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!rsp_valid || rsp.ready) begin
          load_rsp   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign accept = cmd.valid && cmd.ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      end_x  <= cmd.end_x;
      end_y  <= cmd.end_y;
      colour <= cmd.colour;
      half   <= half_in;
      cx     <= sx_in;
      cy     <= sy_in;
      ox     <= -half_in_s;
      oy     <= -half_in_s;
      ax     <= ax_in;
      ay     <= ay_in;
      stx    <= sx_in < cmd.end_x;
      sty    <= sy_in < cmd.end_y;
      err    <= $signed({{(ERR_W-COORD_W){1'b0}}, ax_in}) -
                $signed({{(ERR_W-COORD_W){1'b0}}, ay_in});
      rd_hit <= 1'b0;
    end else if (state == ST_STAMP) begin
      if (!ox_last) begin
        ox <= ox + BRUSH_W'(1);
      end else begin
        ox <= -half_s;
        if (!oy_last) begin
          oy <= oy + BRUSH_W'(1);
        end else begin
          oy <= -half_s;
          if (!at_end) begin
            err <= err_next;
            if (step_x) cx <= stx ? cx + 1'b1 : cx - 1'b1;
            if (step_y) cy <= sty ? cy + 1'b1 : cy - 1'b1;
          end
        end
      end
    end else if (state == ST_READ) begin
      rd_hit <= tex_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) wr_en <= 1'b0;
    else     wr_en <= (state == ST_STAMP) && tex_ok;
  end

  always_ff @(posedge clk) begin
    wr_addr <= tex_addr;
    wr_data <= colour;
  end

  always_ff @(posedge clk) begin
    if (wr_en) page_store[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= page_store[tex_addr];
  end

  always_ff @(posedge clk) begin
    if (rst)                 rsp_valid <= 1'b0;
    else if (load_rsp)       rsp_valid <= 1'b1;
    else if (rsp.ready)      rsp_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp_pixel   <= rd_hit ? rd_data : '0;
      rsp_in_page <= rd_hit;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.pixel_value = rsp_pixel;
  assign rsp.in_page     = rsp_in_page;

  `BRL_ASSERT_NOW(a_no_rd_wr_overlap, rd_en, !wr_en, "read issued while a write is pending")
  `BRL_ASSERT_NOW(a_wr_from_stamp, wr_en, $past(state) == ST_STAMP, "write outside stamping")
  `BRL_ASSERT_NOW(a_offset_bounds, state == ST_STAMP, offs_ok, "brush offset out of range")
  `BRL_ASSERT_NEXT(a_read_finishes, state == ST_READ, state == ST_FINISH, "read did not finish")

endmodule
